@@ hdl/d_ary_min_heap_sorter_unit_assert.svh @@
// Assertion macros shared by the checker files of the heap sorter.
// Each macro places one labeled concurrent assertion on clk_i, disabled in reset.
`ifndef D_ARY_MIN_HEAP_SORTER_UNIT_ASSERT_SVH
`define D_ARY_MIN_HEAP_SORTER_UNIT_ASSERT_SVH

// Same-cycle implication: the consequent must hold where the antecedent holds.
`define DAHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define DAHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/dahs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dahs_pkg
// Types, codes and constants shared by the d-ary min-heap sorter modules.
// ----------------------------------------------------------------------------
package dahs_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned CAPACITY_DEF  = 32;
  localparam int unsigned MAX_ARITY_DEF = 8;

  // Key width and arity register settings.
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned ARITY_W   = 4;
  localparam int unsigned ARITY_MIN = 2;
  localparam int unsigned ARITY_RST = 2;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DRAINED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  // Input and result payloads.
  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] value;
  } dahs_in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    status_e                 status;
    logic                    last;
  } dahs_out_t;

  // Item mode codes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DRAIN  = 1'b1;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_SU_CHECK,
    S_SU_DIV,
    S_SU_READ,
    S_SU_CMP,
    S_EMIT,
    S_DR_TOP,
    S_DR_EMIT,
    S_DR_TAIL,
    S_SD_START,
    S_SD_SCAN,
    S_SD_DECIDE
  } state_e;

  // Read address selection for the heap store.
  typedef enum logic [2:0] {
    RD_ROOT,
    RD_PARENT,
    RD_TAIL,
    RD_FIRST,
    RD_NEXT
  } rd_sel_e;

  // Write source selection for the heap store; the address is always the hole.
  typedef enum logic [1:0] {
    WR_KEY,
    WR_RDATA,
    WR_BEST
  } wr_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    ins_start;
    logic    div_start;
    logic    rd_en;
    rd_sel_e rd_sel;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    pos_ld_parent;
    logic    pos_ld_best;
    logic    pos_clr;
    logic    key_ld_rdata;
    logic    scan_init;
    logic    scan;
    logic    out_load;
    status_e out_code;
    logic    cnt_dec;
  } dahs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic item_mode;
    logic full;
    logic empty;
    logic cnt_one;
    logic pos_zero;
    logic div_done;
    logic up_less;
    logic has_child;
    logic more;
    logic down_less;
    logic out_free;
  } dahs_sts_t;

endpackage

@@ hdl/dahs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dahs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dahs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/dahs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dahs_dp
// Heap datapath: key store, element count, hole pointer, parent divider,
// child scan and the result register.
// ----------------------------------------------------------------------------
module dahs_dp #(
  parameter int unsigned CAPACITY  = 32,
  parameter int unsigned MAX_ARITY = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [dahs_pkg::ARITY_W-1:0]        cfg_data_i,
  input  dahs_pkg::dahs_in_t                  in_data_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output dahs_pkg::dahs_out_t                 out_data_o,
  input  dahs_pkg::dahs_cmd_t                 cmd_i,
  output dahs_pkg::dahs_sts_t                 sts_o
);
  import dahs_pkg::*;

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned DW  = $clog2(MAX_ARITY + 1);
  localparam int unsigned FW  = AW + DW;
  localparam int unsigned DCW = $clog2(AW + 1);

  // Control registers.
  logic [DW-1:0]  d_q, d_d;
  logic [CW-1:0]  count_q, count_d;
  logic           busy_q, busy_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic           out_valid_q, out_valid_d;

  // Payload registers.
  logic [AW-1:0]           pos_q, pos_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [DW-1:0]           rem_q, rem_d;
  logic [AW-1:0]           nq_q, nq_d;
  logic [AW-1:0]           idx_q, idx_d;
  logic [DW-1:0]           ccnt_q, ccnt_d;
  logic signed [KEY_W-1:0] best_q, best_d;
  logic [AW-1:0]           best_idx_q, best_idx_d;
  dahs_out_t               out_q, out_d;

  // Store ports and derived values.
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [KEY_W-1:0]        wdata;
  logic [AW-1:0]           raddr;
  logic [KEY_W-1:0]        rdata;
  logic signed [KEY_W-1:0] rkey;
  logic [DW-1:0]           arity_eff;
  logic [FW-1:0]           first;
  logic [CW-1:0]           nxt;
  logic [DW:0]             trial;
  logic                    ge;
  logic                    out_free;
  logic                    more;

  dahs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rkey = $signed(rdata);

  // Clamp the written arity into the supported range.
  always_comb begin
    if (cfg_data_i < ARITY_W'(ARITY_MIN)) begin
      arity_eff = DW'(ARITY_MIN);
    end else if (32'(cfg_data_i) > MAX_ARITY) begin
      arity_eff = DW'(MAX_ARITY);
    end else begin
      arity_eff = DW'(cfg_data_i);
    end
  end

  // First child of the hole and the next sibling during a scan.
  assign first = FW'(d_q) * FW'(pos_q) + FW'(1);
  assign nxt   = CW'(idx_q) + CW'(1);
  assign more  = (ccnt_q < d_q) && (nxt < count_q);

  // One restoring division step for the parent index.
  assign trial = {rem_q, nq_q[AW-1]};
  assign ge    = trial >= {1'b0, d_q};

  // Read address selection.
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_ROOT:   raddr = '0;
      RD_PARENT: raddr = nq_q;
      RD_TAIL:   raddr = AW'(count_q - CW'(1));
      RD_FIRST:  raddr = AW'(first);
      RD_NEXT:   raddr = AW'(nxt);
      default:   raddr = '0;
    endcase
  end

  // Writes always land on the hole.
  assign we    = cmd_i.wr_en;
  assign waddr = pos_q;
  always_comb begin
    unique case (cmd_i.wr_sel)
      WR_KEY:   wdata = key_q;
      WR_RDATA: wdata = rdata;
      WR_BEST:  wdata = best_q;
      default:  wdata = key_q;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next values of all registers.
  always_comb begin
    d_d         = d_q;
    count_d     = count_q;
    busy_d      = busy_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    key_d       = key_q;
    rem_d       = rem_q;
    nq_d        = nq_q;
    idx_d       = idx_q;
    ccnt_d      = ccnt_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    out_d       = out_q;

    if (cfg_valid_i) begin
      d_d = arity_eff;
    end

    // Element count.
    if (cmd_i.ins_start) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end

    // Hole position.
    if (cmd_i.ins_start) begin
      pos_d = AW'(count_q);
    end else if (cmd_i.pos_clr) begin
      pos_d = '0;
    end else if (cmd_i.pos_ld_parent) begin
      pos_d = nq_q;
    end else if (cmd_i.pos_ld_best) begin
      pos_d = best_idx_q;
    end

    // Key being sifted.
    if (cmd_i.ins_start) begin
      key_d = in_data_i.value;
    end else if (cmd_i.key_ld_rdata) begin
      key_d = rkey;
    end

    // Parent divider: (pos - 1) / d, one quotient bit a cycle.
    if (cmd_i.div_start) begin
      busy_d = 1'b1;
      dcnt_d = DCW'(AW - 1);
      rem_d  = '0;
      nq_d   = pos_q - AW'(1);
    end else if (busy_q) begin
      rem_d = ge ? DW'(trial - {1'b0, d_q}) : DW'(trial);
      nq_d  = AW'({nq_q, ge});
      if (dcnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        dcnt_d = dcnt_q - DCW'(1);
      end
    end

    // Child scan keeps the first smallest child.
    if (cmd_i.scan_init) begin
      idx_d  = AW'(first);
      ccnt_d = DW'(1);
    end else if (cmd_i.scan) begin
      if ((ccnt_q == DW'(1)) || (rkey < best_q)) begin
        best_d     = rkey;
        best_idx_d = idx_q;
      end
      if (more) begin
        idx_d  = AW'(nxt);
        ccnt_d = ccnt_q + DW'(1);
      end
    end

    // Result register.
    if (cmd_i.out_load) begin
      out_valid_d    = 1'b1;
      out_d.status   = cmd_i.out_code;
      if (cmd_i.out_code == ST_DRAINED) begin
        out_d.key_out = rkey;
        out_d.last    = (count_q == CW'(1));
      end else begin
        out_d.key_out = '0;
        out_d.last    = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_q         <= DW'(ARITY_RST);
      count_q     <= '0;
      busy_q      <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      d_q         <= d_d;
      count_q     <= count_d;
      busy_q      <= busy_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    key_q      <= key_d;
    rem_q      <= rem_d;
    nq_q       <= nq_d;
    idx_q      <= idx_d;
    ccnt_q     <= ccnt_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_q      <= out_d;
  end

  // Status toward the controller.
  always_comb begin
    sts_o.item_mode = in_data_i.mode;
    sts_o.full      = (count_q == CW'(CAPACITY));
    sts_o.empty     = (count_q == '0);
    sts_o.cnt_one   = (count_q == CW'(1));
    sts_o.pos_zero  = (pos_q == '0);
    sts_o.div_done  = busy_q && (dcnt_q == '0);
    sts_o.up_less   = key_q < rkey;
    sts_o.has_child = first < FW'(count_q);
    sts_o.more      = more;
    sts_o.down_less = best_q < key_q;
    sts_o.out_free  = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/dahs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dahs_ctrl
// Sequencer for insert (sift-up) and drain (remove minimum, sift-down).
// ----------------------------------------------------------------------------
module dahs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dahs_pkg::dahs_sts_t sts_i,
  output dahs_pkg::dahs_cmd_t cmd_o
);
  import dahs_pkg::*;

  state_e  state_q, state_d;
  status_e res_q, res_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and pending result code.
  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.item_mode == MODE_INSERT) begin
            if (sts_i.full) begin
              res_d   = ST_FULL;
              state_d = S_EMIT;
            end else begin
              res_d   = ST_INSERTED;
              state_d = S_SU_CHECK;
            end
          end else if (sts_i.empty) begin
            res_d   = ST_EMPTY;
            state_d = S_EMIT;
          end else begin
            state_d = S_DR_TOP;
          end
        end
      end
      S_SU_CHECK:  state_d = sts_i.pos_zero ? S_EMIT : S_SU_DIV;
      S_SU_DIV:    state_d = sts_i.div_done ? S_SU_READ : S_SU_DIV;
      S_SU_READ:   state_d = S_SU_CMP;
      S_SU_CMP:    state_d = sts_i.up_less ? S_SU_CHECK : S_EMIT;
      S_EMIT:      state_d = sts_i.out_free ? S_IDLE : S_EMIT;
      S_DR_TOP:    state_d = S_DR_EMIT;
      S_DR_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.cnt_one ? S_IDLE : S_DR_TAIL;
        end
      end
      S_DR_TAIL:   state_d = S_SD_START;
      S_SD_START:  state_d = sts_i.has_child ? S_SD_SCAN : S_DR_TOP;
      S_SD_SCAN:   state_d = sts_i.more ? S_SD_SCAN : S_SD_DECIDE;
      S_SD_DECIDE: state_d = sts_i.down_less ? S_SD_START : S_DR_TOP;
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o          = '0;
    cmd_o.out_code = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (sts_i.item_mode == MODE_INSERT) && !sts_i.full) begin
          cmd_o.ins_start = 1'b1;
        end
      end
      S_SU_CHECK: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_KEY;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      S_SU_DIV: begin
        cmd_o.div_start = 1'b0;
      end
      S_SU_READ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PARENT;
      end
      S_SU_CMP: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.up_less) begin
          // Parent moves down into the hole.
          cmd_o.wr_sel        = WR_RDATA;
          cmd_o.pos_ld_parent = 1'b1;
        end else begin
          cmd_o.wr_sel = WR_KEY;
        end
      end
      S_EMIT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      S_DR_TOP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_ROOT;
      end
      S_DR_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_code = ST_DRAINED;
          cmd_o.cnt_dec  = 1'b1;
          if (!sts_i.cnt_one) begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RD_TAIL;
          end
        end
      end
      S_DR_TAIL: begin
        cmd_o.key_ld_rdata = 1'b1;
        cmd_o.pos_clr      = 1'b1;
      end
      S_SD_START: begin
        if (sts_i.has_child) begin
          cmd_o.rd_en     = 1'b1;
          cmd_o.rd_sel    = RD_FIRST;
          cmd_o.scan_init = 1'b1;
        end else begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_sel = WR_KEY;
        end
      end
      S_SD_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.rd_en  = sts_i.more;
        cmd_o.rd_sel = RD_NEXT;
      end
      S_SD_DECIDE: begin
        cmd_o.wr_en = 1'b1;
        if (sts_i.down_less) begin
          // Smallest child moves up into the hole.
          cmd_o.wr_sel      = WR_BEST;
          cmd_o.pos_ld_best = 1'b1;
        end else begin
          cmd_o.wr_sel = WR_KEY;
        end
      end
      default: begin
        cmd_o.out_load = 1'b0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      res_q   <= ST_INSERTED;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

@@ hdl/d_ary_min_heap_sorter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// d_ary_min_heap_sorter_unit
// Min-heap of signed keys held as a complete d-ary tree in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// An input transaction (in_valid_i/in_ready_o) carries a mode and a key. Insert
// gives one result: inserted, or full-and-dropped. Drain gives one result per
// stored key in ascending order with last set on the final one, or a single
// empty result. Results leave through out_valid_o/out_ready_i.
// The arity register is written on cfg_valid_i; the user must write it only while
// the block is idle, which the block does not enforce. cfg_ready_o is always high.
// Values below 2 act as 2, above MAX_ARITY as MAX_ARITY.
// An insert result follows the parent compares of its sift-up; each compare runs
// the bit-serial parent divider and one read of the store. A drain compares the
// children of each node on the key's way down, one child read a cycle.
// One item is in work at a time; in_ready_o is high only while idle.
// Reset empties the heap and sets the arity to 2; no clearing pass is needed.
// A result waits in the output register while the receiver stalls; a drain
// pauses until its pending result is taken, and an idle block still accepts.
// ----------------------------------------------------------------------------
module d_ary_min_heap_sorter_unit #(
  parameter int unsigned CAPACITY  = dahs_pkg::CAPACITY_DEF,
  parameter int unsigned MAX_ARITY = dahs_pkg::MAX_ARITY_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  dahs_pkg::dahs_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dahs_pkg::dahs_out_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dahs_pkg::ARITY_W-1:0] cfg_data_i
);
  import dahs_pkg::*;

  dahs_cmd_t cmd;
  dahs_sts_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg_ready_o = 1'b1;

  dahs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dahs_dp #(
    .CAPACITY  (CAPACITY),
    .MAX_ARITY (MAX_ARITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

@@ hdl/dahs_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dahs_checker
// Port-level checks of the heap sorter, bound to the top level.
// ----------------------------------------------------------------------------
`include "d_ary_min_heap_sorter_unit_assert.svh"

module dahs_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input dahs_pkg::dahs_in_t           in_data_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input dahs_pkg::dahs_out_t          out_data_o,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [dahs_pkg::ARITY_W-1:0] cfg_data_i
);
  import dahs_pkg::*;

  // A stalled result stays valid and unchanged.
  `DAHS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result changed while stalled")

  // Every accepted item makes the block busy in the cycle after acceptance.
  `DAHS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready stayed high after an accepted transaction")

  // A non-final drained key means the drain is still running.
  `DAHS_ASSERT_NOW(a_drain_busy, out_valid_o && !out_data_o.last, !in_ready_o && (out_data_o.status == ST_DRAINED), "non-final result while idle")

endmodule

bind d_ary_min_heap_sorter_unit dahs_checker u_dahs_checker (.*);
